// ----- rtl/blpg_pkg.sv -----
package blpg_pkg;

  localparam int COORD_W     = 6;
  localparam int COLOR_W     = 32;
  // Error term range is about -63 .. +189, so nine signed bits suffice.
  localparam int ERR_W       = 9;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [COLOR_W-1:0] line_color;
  } seg_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_pixel;
  } pix_t;

  // A classified segment: axes already swapped and endpoints ordered.
  typedef struct packed {
    logic               steep;
    logic               dir_neg;
    logic [COORD_W-1:0] major_start;
    logic [COORD_W-1:0] major_end;
    logic [COORD_W-1:0] minor_start;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] ady;
    logic [COLOR_W-1:0] color;
  } job_t;

endpackage

// ----- rtl/blpg_front.sv -----
module blpg_front #(
  parameter int GRID_MAX = 63
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  blpg_pkg::seg_t segment,
  output logic          busy,
  output blpg_pkg::job_t job,
  output logic          job_valid,
  input  logic          job_ready
);
  import blpg_pkg::*;

  localparam logic [COORD_W-1:0] GRID_LIM = COORD_W'(GRID_MAX);

  logic               accept;
  logic [COORD_W-1:0] ax, ay, bx, by;
  logic [COORD_W-1:0] adx, ady;
  logic               steep;
  logic [COORD_W-1:0] sa_maj, sa_min, sb_maj, sb_min;
  job_t               job_next;

  function automatic logic [COORD_W-1:0] clamp(input logic [COORD_W-1:0] v);
    return (v > GRID_LIM) ? GRID_LIM : v;
  endfunction

  assign busy   = job_valid && !job_ready;
  assign accept = start && !busy;

  always_comb begin
    ax    = clamp(segment.start_x);
    ay    = clamp(segment.start_y);
    bx    = clamp(segment.end_x);
    by    = clamp(segment.end_y);
    adx   = (ax > bx) ? ax - bx : bx - ax;
    ady   = (ay > by) ? ay - by : by - ay;
    steep = adx < ady;
    sa_maj = steep ? ay : ax;
    sa_min = steep ? ax : ay;
    sb_maj = steep ? by : bx;
    sb_min = steep ? bx : by;
    job_next.steep = steep;
    job_next.color = segment.line_color;
    job_next.dx    = steep ? ady : adx;
    job_next.ady   = steep ? adx : ady;
    if (sa_maj > sb_maj) begin
      job_next.major_start = sb_maj;
      job_next.major_end   = sa_maj;
      job_next.minor_start = sb_min;
      job_next.dir_neg     = !(sa_min > sb_min);
    end else begin
      job_next.major_start = sa_maj;
      job_next.major_end   = sb_maj;
      job_next.minor_start = sa_min;
      job_next.dir_neg     = !(sb_min > sa_min);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (accept) begin
      job_valid <= 1'b1;
    end else if (job_ready) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job <= job_next;
    end
  end

endmodule

// ----- rtl/blpg_queue.sv -----
module blpg_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  blpg_pkg::job_t push_job,
  output logic           ready,
  input  logic           pop,
  output blpg_pkg::job_t head,
  output logic           head_valid
);
  import blpg_pkg::*;

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign ready      = count != QCNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = mem[rd_ptr];
  assign do_push    = push && ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

endmodule

// ----- rtl/blpg_back.sv -----
module blpg_back (
  input  logic           clk,
  input  logic           rst,
  input  blpg_pkg::job_t head,
  input  logic           head_valid,
  output logic           pop,
  output blpg_pkg::pix_t pixel,
  output logic           pixel_valid
);
  import blpg_pkg::*;

  typedef enum logic {IDLE, RUN} state_t;

  state_t                  state;
  logic [COORD_W-1:0]      major;
  logic [COORD_W-1:0]      minor;
  logic signed [ERR_W-1:0] err;
  job_t                    cur;
  logic                    last;
  logic signed [ERR_W-1:0] err_sum;
  logic signed [ERR_W-1:0] dx_ext;
  logic signed [ERR_W-1:0] dx2_ext;
  logic                    take_step;

  assign last      = major == cur.major_end;
  assign pop       = head_valid && ((state == IDLE) || last);
  assign err_sum   = err + $signed({{(ERR_W-COORD_W-1){1'b0}}, cur.ady, 1'b0});
  assign dx_ext    = $signed({{(ERR_W-COORD_W){1'b0}}, cur.dx});
  assign dx2_ext   = $signed({{(ERR_W-COORD_W-1){1'b0}}, cur.dx, 1'b0});
  assign take_step = err_sum > dx_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      pixel_valid <= 1'b0;
    end else begin
      pixel_valid <= 1'b0;
      unique case (state)
        IDLE: begin
          if (head_valid) begin
            cur   <= head;
            major <= head.major_start;
            minor <= head.minor_start;
            err   <= '0;
            state <= RUN;
          end
        end
        RUN: begin
          pixel_valid       <= 1'b1;
          pixel.pixel_x     <= cur.steep ? minor : major;
          pixel.pixel_y     <= cur.steep ? major : minor;
          pixel.pixel_color <= cur.color;
          pixel.last_pixel  <= last;
          if (last) begin
            // Chain straight into the next queued segment without a gap.
            if (head_valid) begin
              cur   <= head;
              major <= head.major_start;
              minor <= head.minor_start;
              err   <= '0;
            end else begin
              state <= IDLE;
            end
          end else begin
            major <= major + 1'b1;
            if (take_step) begin
              minor <= cur.dir_neg ? minor - 1'b1 : minor + 1'b1;
              err   <= err_sum - dx2_ext;
            end else begin
              err   <= err_sum;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/bresenham_line_pixel_generator_core.sv -----
// The first pixel of a segment, when the line is otherwise idle, passes the input register,
// the queue and the stepping state register before it shows on the result ports.
// Throughput: one pixel per cycle; a segment gives dx+1 pixels (major-axis length plus
// one, at most 64), set by the single stepping unit. Queued segments follow back to back.
// busy rises only when the input stage and the two-entry queue are all full.
// Reset (synchronous, active high) empties the queue and stops any segment in progress.
module bresenham_line_pixel_generator_core #(
  parameter int GRID_MAX = 63
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  blpg_pkg::seg_t segment,
  output logic           busy,
  output blpg_pkg::pix_t pixel,
  output logic           pixel_valid
);
  import blpg_pkg::*;

  job_t front_job;
  logic front_valid;
  logic queue_ready;
  job_t queue_head;
  logic queue_valid;
  logic queue_pop;

  blpg_front #(
    .GRID_MAX(GRID_MAX)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .segment  (segment),
    .busy     (busy),
    .job      (front_job),
    .job_valid(front_valid),
    .job_ready(queue_ready)
  );

  blpg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_valid),
    .push_job  (front_job),
    .ready     (queue_ready),
    .pop       (queue_pop),
    .head      (queue_head),
    .head_valid(queue_valid)
  );

  blpg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (queue_head),
    .head_valid (queue_valid),
    .pop        (queue_pop),
    .pixel      (pixel),
    .pixel_valid(pixel_valid)
  );

endmodule
